@@ src/cprd_pkg.sv @@
// Shared types and constants for the cell pattern run-length decoder.
// Used by every module in src; depends on nothing.
package cprd_pkg;

    // Grid and saturation limits
    localparam int MAX_DIM   = 1024;
    localparam int OUT_CAP   = 1024;
    localparam int LIM_CAP   = (MAX_DIM < OUT_CAP) ? MAX_DIM : OUT_CAP;
    localparam int POS_W     = 11;
    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;

    localparam logic [POS_W-1:0] SAT11     = 11'd2047;
    localparam logic [CFG_W-1:0] DIM_CAP   = CFG_W'(LIM_CAP);
    localparam logic [CFG_W-1:0] DIM_RESET = 11'd64;

    // Register indexes
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // Pattern characters
    localparam logic [7:0] SYM_ZERO = 8'h30;
    localparam logic [7:0] SYM_NINE = 8'h39;
    localparam logic [7:0] SYM_LIVE = 8'h6F;
    localparam logic [7:0] SYM_DEAD = 8'h62;
    localparam logic [7:0] SYM_EOL  = 8'h24;

    // Command kinds handed from front to back
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] CMD_OTHER = 3'd0;
    localparam logic [KIND_W-1:0] CMD_DIGIT = 3'd1;
    localparam logic [KIND_W-1:0] CMD_LIVE  = 3'd2;
    localparam logic [KIND_W-1:0] CMD_DEAD  = 3'd3;
    localparam logic [KIND_W-1:0] CMD_EOL   = 3'd4;

    // Command queue depth (power of two)
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    // Stream widths
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 32;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [3:0]        digit;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ src/cprd_front.sv @@
// Front end: accepts pattern characters and classifies them into commands.
// Depends on cprd_pkg.
module cprd_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cprd_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] symbol
    input  logic                            s_tlast,   // last_symbol
    input  cprd_pkg::q_status_t             q_status,
    output logic                            push,
    output cprd_pkg::cmd_t                  push_cmd
);

    logic [7:0] sym;

    assign sym      = s_tdata[7:0];
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    always_comb begin
        push_cmd.last  = s_tlast;
        push_cmd.digit = 4'(sym - cprd_pkg::SYM_ZERO);
        priority if (sym >= cprd_pkg::SYM_ZERO && sym <= cprd_pkg::SYM_NINE) begin
            push_cmd.kind = cprd_pkg::CMD_DIGIT;
        end else if (sym == cprd_pkg::SYM_LIVE) begin
            push_cmd.kind = cprd_pkg::CMD_LIVE;
        end else if (sym == cprd_pkg::SYM_DEAD) begin
            push_cmd.kind = cprd_pkg::CMD_DEAD;
        end else if (sym == cprd_pkg::SYM_EOL) begin
            push_cmd.kind = cprd_pkg::CMD_EOL;
        end else begin
            push_cmd.kind = cprd_pkg::CMD_OTHER;
        end
    end

endmodule

@@ src/cprd_queue.sv @@
// Short command queue between the front and back ends.
// Depends on cprd_pkg.
module cprd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  cprd_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output cprd_pkg::cmd_t       pop_cmd,
    output cprd_pkg::q_status_t  q_status
);

    cprd_pkg::cmd_t                 mem_reg [cprd_pkg::Q_DEPTH];
    logic [cprd_pkg::Q_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [cprd_pkg::Q_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [cprd_pkg::Q_CW-1:0]      count_reg, count_next;

    assign q_status.full  = (count_reg == cprd_pkg::Q_CW'(cprd_pkg::Q_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_cmd        = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + cprd_pkg::Q_CW'(push) - cprd_pkg::Q_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full || pop)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("command popped from an empty queue");

endmodule

@@ src/cprd_back.sv @@
// Back end: executes decoded commands, tracks position and run count,
// holds the grid registers and the output register. Depends on cprd_pkg.
module cprd_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [cprd_pkg::CFG_W-1:0]      cfg_data,
    input  cprd_pkg::q_status_t             q_status,
    input  cprd_pkg::cmd_t                  pop_cmd,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cprd_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    localparam int PW = cprd_pkg::POS_W;
    localparam int CW = cprd_pkg::COORD_W;

    logic [cprd_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [PW-1:0] row_reg, row_next;
    logic [PW-1:0] col_reg, col_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic          seen_reg, seen_next;

    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_row_reg, out_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [PW-1:0] out_len_reg, out_len_next;
    logic          out_last_reg, out_last_next;

    logic [PW-1:0] n, w_lim, h_lim, room, run_len;
    logic [14:0]   cnt_mul;
    logic [15:0]   cnt_sum;
    logic [PW:0]   col_sum, row_sum;
    logic [PW-1:0] col_adv, row_adv;
    logic          live_hit, emit;

    always_comb begin
        n       = seen_reg ? cnt_reg : PW'(1);
        w_lim   = (width_reg  > cprd_pkg::DIM_CAP) ? cprd_pkg::DIM_CAP : width_reg;
        h_lim   = (height_reg > cprd_pkg::DIM_CAP) ? cprd_pkg::DIM_CAP : height_reg;
        room    = w_lim - col_reg;
        run_len = (n < room) ? n : room;
        // count * 10 as two shifts
        cnt_mul = {1'b0, cnt_reg, 3'b000} + {3'b000, cnt_reg, 1'b0};
        cnt_sum = {1'b0, cnt_mul} + {12'd0, pop_cmd.digit};
        col_sum = {1'b0, col_reg} + {1'b0, n};
        row_sum = {1'b0, row_reg} + {1'b0, n};
        col_adv = col_sum[PW] ? cprd_pkg::SAT11 : col_sum[PW-1:0];
        row_adv = row_sum[PW] ? cprd_pkg::SAT11 : row_sum[PW-1:0];
        live_hit = (row_reg < h_lim) && (col_reg < w_lim) && (n != '0);
    end

    // Fire when a command waits and the output register is free or draining
    assign pop = !q_status.empty && (!out_valid_reg || m_tready);

    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        cnt_next  = cnt_reg;
        seen_next = seen_reg;
        emit      = 1'b0;

        out_valid_next = out_valid_reg && !m_tready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;

        if (pop) begin
            unique case (pop_cmd.kind)
                cprd_pkg::CMD_DIGIT: begin
                    cnt_next  = (cnt_sum > 16'(cprd_pkg::SAT11)) ? cprd_pkg::SAT11
                                                                : cnt_sum[PW-1:0];
                    seen_next = 1'b1;
                end
                cprd_pkg::CMD_LIVE: begin
                    emit      = live_hit;
                    col_next  = col_adv;
                    cnt_next  = '0;
                    seen_next = 1'b0;
                end
                cprd_pkg::CMD_DEAD: begin
                    col_next  = col_adv;
                    cnt_next  = '0;
                    seen_next = 1'b0;
                end
                cprd_pkg::CMD_EOL: begin
                    row_next  = row_adv;
                    col_next  = '0;
                    cnt_next  = '0;
                    seen_next = 1'b0;
                end
                default: begin
                end
            endcase

            if (emit || pop_cmd.last) begin
                out_valid_next = 1'b1;
                out_row_next   = emit ? row_reg[CW-1:0] : '0;
                out_col_next   = emit ? col_reg[CW-1:0] : '0;
                out_len_next   = emit ? run_len : '0;
                out_last_next  = pop_cmd.last;
            end

            // Return to the origin after the closing character
            if (pop_cmd.last) begin
                row_next  = '0;
                col_next  = '0;
                cnt_next  = '0;
                seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= cprd_pkg::DIM_RESET;
            height_reg    <= cprd_pkg::DIM_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == cprd_pkg::REG_GRID_WIDTH) begin
                width_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == cprd_pkg::REG_GRID_HEIGHT) begin
                height_reg <= cfg_data;
            end
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_len_reg, out_col_reg, out_row_reg};

    a_run_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_last_reg |-> out_len_reg != '0)
        else $error("result without done mark carries no live cells");

    a_run_clipped: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ({1'b0, out_col_reg} + out_len_reg) <= w_lim)
        else $error("live run extends past the grid width");

    a_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> cnt_reg == '0)
        else $error("run count held without a digit seen");

endmodule

@@ src/cell_pattern_rle_decoder_unit.sv @@
// Path: the edge that accepts a character writes its command into the queue; the back
// end pops it once the output register is free and registers its result there.
// Throughput: one character per cycle sustained while the queue has room; the back end executes one
// queued command per cycle and stalls only while the output register is held.
// Reset: aresetn is synchronous, active low; it empties the queue, drops any
// pending result, clears position and count, and sets width and height to 64.
module cell_pattern_rle_decoder_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic                            cfg_index,  // 0: grid_width, 1: grid_height
    input  logic [cprd_pkg::CFG_W-1:0]      cfg_data,
    // Character stream in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cprd_pkg::S_DATA_W-1:0]   s_tdata,    // [7:0] symbol
    input  logic                            s_tlast,    // last_symbol
    // Live run stream out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cprd_pkg::M_DATA_W-1:0]   m_tdata,    // [9:0] run_row, [19:10] run_col,
                                                        // [30:20] run_length, [31] zero
    output logic                            m_tlast     // done_res
);

    // Front to queue
    logic                 push;
    cprd_pkg::cmd_t       push_cmd;

    // Queue to back
    logic                 pop;
    cprd_pkg::cmd_t       pop_cmd;
    cprd_pkg::q_status_t  q_status;

    // Classify each accepted character; hold off the source when the queue fills
    cprd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Decouple the input side from output stalls
    cprd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    // Advance position and count, clip runs, register results
    cprd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ bench/cprd_run_checker.sv @@
// Scoreboard for the cell pattern run-length decoder: watches the config port and both
// streams, predicts each run word from accepted characters and compares in order.
// Depends on cprd_pkg for widths and character codes.
module cprd_run_checker
    import cprd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // [9:0] row, [19:10] col, [30:20] length, [31] 0
    input  logic                m_tlast,
    output int                  fail_count,
    output int                  pending_runs
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [POS_W-1:0]   len;
        logic               done;
    } run_word_t;

    localparam int PRINT_CAP = 100;

    run_word_t          expected_runs[$];
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [POS_W-1:0]   row_pos;
    logic [POS_W-1:0]   col_pos;
    logic [POS_W-1:0]   pend_count;
    logic               count_valid;
    int                 printed;
    run_word_t          want;

    initial begin
        fail_count   = 0;
        pending_runs = 0;
        printed      = 0;
    end

    function automatic logic [POS_W-1:0] grid_limit(input logic [CFG_W-1:0] reg_val);
        return (reg_val > DIM_CAP) ? DIM_CAP : reg_val;
    endfunction

    function automatic logic [POS_W-1:0] sat_step(input logic [POS_W-1:0] pos,
                                                  input logic [POS_W-1:0] amount);
        logic [POS_W:0] sum;
        sum = pos + amount;
        return (sum > SAT11) ? SAT11 : sum[POS_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned wanted);
        fail_count++;
        if (printed < PRINT_CAP) begin
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, wanted);
            printed++;
        end
    endtask

    // Advance position and count for one character; queue the run word it causes.
    task automatic decode_char(input logic [7:0] sym, input logic lst);
        logic [POS_W-1:0] n;
        logic [POS_W-1:0] w;
        logic [POS_W-1:0] h;
        logic [POS_W-1:0] room;
        int unsigned      acc;
        logic             hit;
        run_word_t        res;
        n   = count_valid ? pend_count : POS_W'(1);
        w   = grid_limit(width_reg);
        h   = grid_limit(height_reg);
        res = '0;
        hit = 1'b0;
        if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
            acc         = pend_count * 10 + (sym - SYM_ZERO);
            pend_count  = (acc > SAT11) ? SAT11 : acc[POS_W-1:0];
            count_valid = 1'b1;
        end else if (sym == SYM_LIVE) begin
            if (row_pos < h && col_pos < w && n != 0) begin
                room    = w - col_pos;
                hit     = 1'b1;
                res.row = row_pos[COORD_W-1:0];
                res.col = col_pos[COORD_W-1:0];
                res.len = (n < room) ? n : room;
            end
            col_pos     = sat_step(col_pos, n);
            pend_count  = '0;
            count_valid = 1'b0;
        end else if (sym == SYM_DEAD) begin
            col_pos     = sat_step(col_pos, n);
            pend_count  = '0;
            count_valid = 1'b0;
        end else if (sym == SYM_EOL) begin
            row_pos     = sat_step(row_pos, n);
            col_pos     = '0;
            pend_count  = '0;
            count_valid = 1'b0;
        end
        // the closing character sends the pattern back to the origin
        if (lst) begin
            row_pos     = '0;
            col_pos     = '0;
            pend_count  = '0;
            count_valid = 1'b0;
        end
        if (hit || lst) begin
            res.done = lst;
            expected_runs = {expected_runs, res};
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   = DIM_RESET;
            height_reg  = DIM_RESET;
            row_pos     = '0;
            col_pos     = '0;
            pend_count  = '0;
            count_valid = 1'b0;
            expected_runs.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_GRID_WIDTH) begin
                    width_reg = cfg_data;
                end else begin
                    height_reg = cfg_data;
                end
            end
            // check the output before predicting: a word never comes from this edge's input
            if (m_tvalid && m_tready) begin
                if (expected_runs.size() == 0) begin
                    report_mismatch("run word with none expected, tdata", m_tdata, 0);
                end else begin
                    want = expected_runs.pop_front();
                    if (m_tdata[9:0] !== want.row)
                        report_mismatch("run_row", m_tdata[9:0], want.row);
                    if (m_tdata[19:10] !== want.col)
                        report_mismatch("run_col", m_tdata[19:10], want.col);
                    if (m_tdata[30:20] !== want.len)
                        report_mismatch("run_length", m_tdata[30:20], want.len);
                    if (m_tdata[31] !== 1'b0)
                        report_mismatch("tdata pad bit", m_tdata[31], 0);
                    if (m_tlast !== want.done)
                        report_mismatch("done_res", m_tlast, want.done);
                end
            end
            if (s_tvalid && s_tready) begin
                decode_char(s_tdata, s_tlast);
            end
        end
        pending_runs = expected_runs.size();
    end

endmodule

@@ bench/cell_pattern_rle_decoder_unit_tb.sv @@
// Top of the decoder bench: clock, reset, config writes, character stimulus and verdict.
// Depends on cprd_pkg, cell_pattern_rle_decoder_unit and cprd_run_checker.
module cell_pattern_rle_decoder_unit_tb
    import cprd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 16;     // well past the output register and the queue depth
    localparam int PHASE_CHARS   = 250;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = REG_GRID_WIDTH;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;    // [7:0] symbol
    logic                s_tlast   = 1'b0;  // last_symbol
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;           // [9:0] run_row, [19:10] run_col,
                                            // [30:20] run_length, [31] zero
    logic                m_tlast;           // done_res

    int fail_count;
    int pending_runs;
    int idle_pct     = 0;   // chance per cycle that the sender holds off
    int stall_pct    = 0;   // chance per cycle that the receiver stalls
    int pattern_chars = 0;  // pattern characters sent, noise excluded
    int cycle_count  = 0;

    cell_pattern_rle_decoder_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    cprd_run_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending_runs (pending_runs)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: stall at random, at the rate the current phase sets
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Hand one character to the block; return at the edge that accepts it.
    task automatic push_char(input logic [7:0] sym, input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Send a decimal count (none if negative) followed by a pattern symbol.
    task automatic send_token(input int count, input logic [7:0] sym, input logic lst);
        string digits;
        digits = (count < 0) ? "" : $sformatf("%0d", count);
        for (int i = 0; i < digits.len(); i++) begin
            push_char(digits[i], 1'b0);
        end
        push_char(sym, lst);
    endtask

    // One well-formed pattern with random content, laced with stray characters.
    task automatic send_pattern();
        int         tokens;
        int         ndig;
        int         pick;
        logic [7:0] sym;
        tokens = $urandom_range(3, 24);
        for (int i = 0; i < tokens; i++) begin
            // noise: any byte, now and then closing the pattern early
            if ($urandom_range(9) == 0) begin
                push_char(8'($urandom_range(255)), ($urandom_range(19) == 0));
            end
            pick = $urandom_range(99);
            ndig = (pick < 30) ? 0 : (pick < 80) ? 1 : (pick < 95) ? 2 : $urandom_range(3, 4);
            repeat (ndig) begin
                push_char(SYM_ZERO + 8'($urandom_range(9)), 1'b0);
                pattern_chars++;
            end
            pick = $urandom_range(99);
            sym  = (pick < 50) ? SYM_LIVE : (pick < 80) ? SYM_DEAD : SYM_EOL;
            push_char(sym, (i == tokens - 1));
            pattern_chars++;
        end
    endtask

    // Drop valid, wait for every predicted word, then let queued no-result words drain.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_runs == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int target;
        int ph;
        int w;
        int h;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part on the reset grid of 64 x 64
        send_token(-1, SYM_LIVE, 1'b0);    // bare live cell at the origin
        send_token(0, SYM_LIVE, 1'b0);     // explicit zero count: no run
        send_token(99, SYM_LIVE, 1'b0);    // run clipped at the right edge
        send_token(9999, SYM_DEAD, 1'b0);  // count and column both saturate
        send_token(-1, SYM_LIVE, 1'b0);    // column past the width: dropped
        send_token(0, SYM_EOL, 1'b0);      // zero-row line end, column back to 0
        push_char(8'hFF, 1'b0);            // not a pattern character: ignored
        send_token(9999, SYM_EOL, 1'b0);   // row saturates
        send_token(-1, SYM_LIVE, 1'b1);    // dropped run on the closing word: done only
        push_char(8'h00, 1'b1);            // ignored character closing the pattern
        send_token(5, SYM_EOL, 1'b0);
        send_token(7, SYM_DEAD, 1'b0);
        send_token(-1, SYM_LIVE, 1'b1);    // live run and done in one word
        wait_drained();

        // Random part: one grid setting and one idling mix per phase
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    w = 16;   h = 8;    idle_pct = 0;  stall_pct = 0;
                end
                1: begin
                    w = 1;    h = 1024; idle_pct = 80; stall_pct = 0;
                end
                2: begin
                    w = 1024; h = 1;    idle_pct = 0;  stall_pct = 80;
                end
                3: begin
                    w = 2047; h = 2047; idle_pct = 32; stall_pct = 32;
                end
                4: begin
                    w = 0;    h = 0;    idle_pct = 0;  stall_pct = 0;
                end
                default: begin
                    w = $urandom_range(1, 100);
                    h = $urandom_range(1, 40);
                    idle_pct = 32; stall_pct = 32;
                end
            endcase
            write_reg(REG_GRID_WIDTH, CFG_W'(w));
            write_reg(REG_GRID_HEIGHT, CFG_W'(h));
            target = pattern_chars + PHASE_CHARS;
            while (pattern_chars < target) send_pattern();
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/cprd_pkg.sv
src/cprd_front.sv
src/cprd_queue.sv
src/cprd_back.sv
src/cell_pattern_rle_decoder_unit.sv
bench/cprd_run_checker.sv
bench/cell_pattern_rle_decoder_unit_tb.sv
